// ----- rtl/polar_gaussian_transform_unit_defines.svh -----
// Assertion macros for the polar Gaussian transform unit.
`ifndef POLAR_GAUSSIAN_TRANSFORM_UNIT_DEFINES_SVH
`define POLAR_GAUSSIAN_TRANSFORM_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PGT_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("pgt assertion failed");
`define PGT_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("pgt assertion failed");
`else
`define PGT_ASSERT(label, prop)
`define PGT_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ----- rtl/pgt_pkg.sv -----
`timescale 1ns / 1ps
package pgt_pkg;

    localparam int LOG_BITS    = 58;
    localparam int NORM_STAGES = 6;
    localparam int DIV_STEPS   = 64;
    localparam int SQRT_STEPS  = 32;
    localparam int LANES       = 2;

    localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] TWO_LN2_Q62 = 64'h58B9_0BFB_E8E7_BCD6;

    typedef struct packed {
        logic        acc;
        logic        neg_a;
        logic        neg_b;
        logic [63:0] sq_a;
        logic [63:0] sq_b;
        logic [63:0] m;
        logic [5:0]  sh;
    } ctx_t;

endpackage

// ----- rtl/pgt_mul64.sv -----
`timescale 1ns / 1ps
module pgt_mul64 (
    input  logic         aclk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] prod
);

    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] prod_reg, prod_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg <= 64'(a[31:0])  * 64'(b[31:0]);
            p01_reg <= 64'(a[31:0])  * 64'(b[63:32]);
            p10_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            p11_reg <= 64'(a[63:32]) * 64'(b[63:32]);
        end
    end

    always_comb begin
        prod_next = {p11_reg, 64'd0} + {32'd0, p01_reg, 32'd0}
                  + {32'd0, p10_reg, 32'd0} + {64'd0, p00_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/pgt_log_cell.sv -----
`timescale 1ns / 1ps
module pgt_log_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [63:0]    in_x,
    input  logic [57:0]    in_frac,
    input  pgt_pkg::ctx_t  in_ctx,
    output logic           out_valid,
    output logic [63:0]    out_x,
    output logic [57:0]    out_frac,
    output pgt_pkg::ctx_t  out_ctx
);

    logic [127:0]  sq_prod;
    logic [63:0]   xn;
    logic [1:0]    valid_reg;
    logic [57:0]   frac1_reg, frac2_reg;
    pgt_pkg::ctx_t ctx1_reg, ctx2_reg;

    pgt_mul64 u_square (
        .aclk (aclk),
        .en   (en),
        .a    (in_x),
        .b    (in_x),
        .prod (sq_prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            frac1_reg <= in_frac;
            frac2_reg <= frac1_reg;
            ctx1_reg  <= in_ctx;
            ctx2_reg  <= ctx1_reg;
        end
    end

    // renormalize to [1,2) and take one fraction bit
    always_comb begin
        xn       = sq_prod[125:62];
        out_x    = xn[63] ? (xn >> 1) : xn;
        out_frac = {frac2_reg[56:0], xn[63]};
    end

    assign out_valid = valid_reg[1];
    assign out_ctx   = ctx2_reg;

endmodule

// ----- rtl/pgt_div_cell.sv -----
`timescale 1ns / 1ps
module pgt_div_cell (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  pgt_pkg::ctx_t                          in_ctx,
    input  logic [pgt_pkg::LANES-1:0][63:0]        in_r,
    input  logic [pgt_pkg::LANES-1:0][63:0]        in_lo,
    input  logic [pgt_pkg::LANES-1:0][63:0]        in_q,
    output logic                                   out_valid,
    output pgt_pkg::ctx_t                          out_ctx,
    output logic [pgt_pkg::LANES-1:0][63:0]        out_r,
    output logic [pgt_pkg::LANES-1:0][63:0]        out_lo,
    output logic [pgt_pkg::LANES-1:0][63:0]        out_q
);

    logic                                   valid_reg;
    pgt_pkg::ctx_t                          ctx_reg;
    logic [pgt_pkg::LANES-1:0][63:0]        r_reg, r_next;
    logic [pgt_pkg::LANES-1:0][63:0]        lo_reg, lo_next;
    logic [pgt_pkg::LANES-1:0][63:0]        q_reg, q_next;
    logic [pgt_pkg::LANES-1:0][63:0]        rs;
    logic [pgt_pkg::LANES-1:0]              ge;

    always_comb begin
        for (int i = 0; i < pgt_pkg::LANES; i++) begin
            rs[i]      = {in_r[i][62:0], in_lo[i][63]};
            ge[i]      = rs[i] >= in_ctx.m;
            r_next[i]  = ge[i] ? (rs[i] - in_ctx.m) : rs[i];
            q_next[i]  = {in_q[i][62:0], ge[i]};
            lo_next[i] = {in_lo[i][62:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg <= in_ctx;
            r_reg   <= r_next;
            lo_reg  <= lo_next;
            q_reg   <= q_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctx   = ctx_reg;
    assign out_r     = r_reg;
    assign out_lo    = lo_reg;
    assign out_q     = q_reg;

endmodule

// ----- rtl/pgt_sqrt_cell.sv -----
`timescale 1ns / 1ps
module pgt_sqrt_cell #(
    parameter int BIT_POS = 62
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  pgt_pkg::ctx_t                          in_ctx,
    input  logic [pgt_pkg::LANES-1:0][63:0]        in_n,
    input  logic [pgt_pkg::LANES-1:0][63:0]        in_res,
    output logic                                   out_valid,
    output pgt_pkg::ctx_t                          out_ctx,
    output logic [pgt_pkg::LANES-1:0][63:0]        out_n,
    output logic [pgt_pkg::LANES-1:0][63:0]        out_res
);

    localparam logic [63:0] BIT_VAL = 64'd1 << BIT_POS;

    logic                                   valid_reg;
    pgt_pkg::ctx_t                          ctx_reg;
    logic [pgt_pkg::LANES-1:0][63:0]        n_reg, n_next;
    logic [pgt_pkg::LANES-1:0][63:0]        res_reg, res_next;
    logic [pgt_pkg::LANES-1:0][63:0]        trial;

    always_comb begin
        for (int i = 0; i < pgt_pkg::LANES; i++) begin
            trial[i] = in_res[i] + BIT_VAL;
            if (in_n[i] >= trial[i]) begin
                n_next[i]   = in_n[i] - trial[i];
                res_next[i] = (in_res[i] >> 1) + BIT_VAL;
            end else begin
                n_next[i]   = in_n[i];
                res_next[i] = in_res[i] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg <= in_ctx;
            n_reg   <= n_next;
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctx   = ctx_reg;
    assign out_n     = n_reg;
    assign out_res   = res_reg;

endmodule

// ----- rtl/polar_gaussian_transform_unit.sv -----
// Throughput: one uniform pair per cycle while s_tready is high; the chain is
// 58 log cells, 64 divider cells and 32 square-root cells, all stepping together.
// A one-word skid stage behind the output register takes a result when the output
// stalls; while it is full, the chain is held and s_tready is low.
// Reset (aresetn low, synchronous) clears every valid flag; payload is not reset.
`timescale 1ns / 1ps
`include "polar_gaussian_transform_unit_defines.svh"
module polar_gaussian_transform_unit #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] uniform_a, [63:32] uniform_b
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] deviate_a, [63:32] deviate_b
    output logic [0:0]  m_tuser    // [0] accepted
);

    localparam int SHIFT_IN = 32 - SAMPLE_WIDTH;
    localparam int NS = pgt_pkg::NORM_STAGES;
    localparam int LB = pgt_pkg::LOG_BITS;
    localparam int DS = pgt_pkg::DIV_STEPS;
    localparam int SS = pgt_pkg::SQRT_STEPS;

    logic        pipe_en;
    logic [31:0] a_sx, b_sx;

    // input stage
    logic        v0_reg, neg_a0_reg, neg_b0_reg;
    logic [31:0] mag_a0_reg, mag_b0_reg;
    // square stage
    logic        v1_reg, neg_a1_reg, neg_b1_reg;
    logic [63:0] sq_a1_reg, sq_b1_reg;
    // sum stage
    logic          v2_reg;
    pgt_pkg::ctx_t ctx2_reg, ctx2_next;

    logic          nv   [0:NS];
    logic [63:0]   nx   [0:NS];
    pgt_pkg::ctx_t nctx [0:NS];

    logic          lv    [0:LB];
    logic [63:0]   lx    [0:LB];
    logic [57:0]   lfrac [0:LB];
    pgt_pkg::ctx_t lctx  [0:LB];

    logic          tv_reg;
    logic [63:0]   t_reg;
    pgt_pkg::ctx_t tctx_reg;

    logic [127:0]  prod_c;
    logic [1:0]    cv_reg;
    pgt_pkg::ctx_t cctx1_reg, cctx2_reg;
    logic [63:0]   l_val;

    logic [127:0]  prod_a, prod_b;
    logic [1:0]    pv_reg;
    pgt_pkg::ctx_t pctx1_reg, pctx2_reg;

    logic                                   dv   [0:DS];
    pgt_pkg::ctx_t                          dctx [0:DS];
    logic [pgt_pkg::LANES-1:0][63:0]        dr   [0:DS];
    logic [pgt_pkg::LANES-1:0][63:0]        dlo  [0:DS];
    logic [pgt_pkg::LANES-1:0][63:0]        dq   [0:DS];

    logic                                   sv   [0:SS];
    pgt_pkg::ctx_t                          sctx [0:SS];
    logic [pgt_pkg::LANES-1:0][63:0]        sn   [0:SS];
    logic [pgt_pkg::LANES-1:0][63:0]        sres [0:SS];

    logic [pgt_pkg::LANES-1:0][31:0]        dev;
    logic [pgt_pkg::LANES-1:0]              lane_neg;
    logic [pgt_pkg::LANES-1:0][32:0]        rnd;
    logic [63:0]   res_data;
    logic          res_user;
    logic          res_v;

    logic          m_tvalid_reg, skid_valid_reg;
    logic [63:0]   m_tdata_reg, skid_data_reg;
    logic          m_tuser_reg, skid_user_reg;

    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    assign a_sx = 32'($signed(s_tdata[SAMPLE_WIDTH-1:0])) << SHIFT_IN;
    assign b_sx = 32'($signed(s_tdata[32+SAMPLE_WIDTH-1:32])) << SHIFT_IN;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            tv_reg <= 1'b0;
            cv_reg <= '0;
            pv_reg <= '0;
        end else if (pipe_en) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            tv_reg <= lv[LB];
            cv_reg <= {cv_reg[0], tv_reg};
            pv_reg <= {pv_reg[0], cv_reg[1]};
        end
    end

    always_comb begin
        ctx2_next.neg_a = neg_a1_reg;
        ctx2_next.neg_b = neg_b1_reg;
        ctx2_next.sq_a  = sq_a1_reg;
        ctx2_next.sq_b  = sq_b1_reg;
        ctx2_next.m     = sq_a1_reg + sq_b1_reg;
        ctx2_next.acc   = (ctx2_next.m != 64'd0) && (ctx2_next.m < pgt_pkg::ONE_Q62);
        ctx2_next.sh    = 6'd0;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            neg_a0_reg <= a_sx[31];
            neg_b0_reg <= b_sx[31];
            mag_a0_reg <= a_sx[31] ? (~a_sx + 32'd1) : a_sx;
            mag_b0_reg <= b_sx[31] ? (~b_sx + 32'd1) : b_sx;
            neg_a1_reg <= neg_a0_reg;
            neg_b1_reg <= neg_b0_reg;
            sq_a1_reg  <= 64'(mag_a0_reg) * 64'(mag_a0_reg);
            sq_b1_reg  <= 64'(mag_b0_reg) * 64'(mag_b0_reg);
            ctx2_reg   <= ctx2_next;
            t_reg      <= {lctx[LB].sh, 58'd0} - 64'(lfrac[LB]);
            tctx_reg   <= lctx[LB];
            cctx1_reg  <= tctx_reg;
            cctx2_reg  <= cctx1_reg;
            pctx1_reg  <= cctx2_reg;
            pctx2_reg  <= pctx1_reg;
        end
    end

    // leading-one normalization, bit 62 set after the last step for an accepted (nonzero) sum
    assign nv[0]   = v2_reg;
    assign nx[0]   = ctx2_reg.m;
    assign nctx[0] = ctx2_reg;

    for (genvar k = 0; k < NS; k++) begin : g_norm
        localparam int AMT = 1 << (NS - 1 - k);
        logic          v_reg;
        logic          zero_top;
        logic [63:0]   x_reg, x_next;
        pgt_pkg::ctx_t c_reg, c_next;

        always_comb begin
            zero_top = (nx[k][62 -: AMT] == '0);
            x_next   = nx[k];
            c_next   = nctx[k];
            if (zero_top) begin
                x_next    = nx[k] << AMT;
                c_next.sh = nctx[k].sh + 6'(AMT);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (pipe_en) begin
                v_reg <= nv[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                x_reg <= x_next;
                c_reg <= c_next;
            end
        end

        assign nv[k+1]   = v_reg;
        assign nx[k+1]   = x_reg;
        assign nctx[k+1] = c_reg;
    end

    assign lv[0]    = nv[NS];
    assign lx[0]    = nx[NS];
    assign lfrac[0] = '0;
    assign lctx[0]  = nctx[NS];

    for (genvar k = 0; k < LB; k++) begin : g_log
        pgt_log_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (lv[k]),
            .in_x      (lx[k]),
            .in_frac   (lfrac[k]),
            .in_ctx    (lctx[k]),
            .out_valid (lv[k+1]),
            .out_x     (lx[k+1]),
            .out_frac  (lfrac[k+1]),
            .out_ctx   (lctx[k+1])
        );
    end

    pgt_mul64 u_mul_ln2 (
        .aclk (aclk),
        .en   (pipe_en),
        .a    (t_reg),
        .b    (pgt_pkg::TWO_LN2_Q62),
        .prod (prod_c)
    );

    assign l_val = prod_c[126:63];

    pgt_mul64 u_mul_a (
        .aclk (aclk),
        .en   (pipe_en),
        .a    (cctx2_reg.sq_a),
        .b    (l_val),
        .prod (prod_a)
    );

    pgt_mul64 u_mul_b (
        .aclk (aclk),
        .en   (pipe_en),
        .a    (cctx2_reg.sq_b),
        .b    (l_val),
        .prod (prod_b)
    );

    assign dv[0]      = pv_reg[1];
    assign dctx[0]    = pctx2_reg;
    assign dr[0][0]   = prod_a[127:64];
    assign dr[0][1]   = prod_b[127:64];
    assign dlo[0][0]  = prod_a[63:0];
    assign dlo[0][1]  = prod_b[63:0];
    assign dq[0]      = '0;

    for (genvar k = 0; k < DS; k++) begin : g_div
        pgt_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (dv[k]),
            .in_ctx    (dctx[k]),
            .in_r      (dr[k]),
            .in_lo     (dlo[k]),
            .in_q      (dq[k]),
            .out_valid (dv[k+1]),
            .out_ctx   (dctx[k+1]),
            .out_r     (dr[k+1]),
            .out_lo    (dlo[k+1]),
            .out_q     (dq[k+1])
        );
    end

    assign sv[0]      = dv[DS];
    assign sctx[0]    = dctx[DS];
    assign sn[0][0]   = dq[DS][0] >> 1;
    assign sn[0][1]   = dq[DS][1] >> 1;
    assign sres[0]    = '0;

    for (genvar k = 0; k < SS; k++) begin : g_sqrt
        pgt_sqrt_cell #(
            .BIT_POS (62 - 2 * k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (sv[k]),
            .in_ctx    (sctx[k]),
            .in_n      (sn[k]),
            .in_res    (sres[k]),
            .out_valid (sv[k+1]),
            .out_ctx   (sctx[k+1]),
            .out_n     (sn[k+1]),
            .out_res   (sres[k+1])
        );
    end

    // round half up, apply sign, clamp, zero on reject
    always_comb begin
        lane_neg[0] = sctx[SS].neg_a;
        lane_neg[1] = sctx[SS].neg_b;
        for (int i = 0; i < pgt_pkg::LANES; i++) begin
            rnd[i] = (33'(sres[SS][i][31:0]) + 33'd1) >> 1;
            if (!sctx[SS].acc) begin
                dev[i] = 32'd0;
            end else if (lane_neg[i]) begin
                dev[i] = (rnd[i] > 33'h0_8000_0000) ? 32'h8000_0000
                                                    : 32'(33'd0 - rnd[i]);
            end else begin
                dev[i] = (rnd[i] > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rnd[i][31:0];
            end
        end
        res_data = {dev[1], dev[0]};
        res_user = sctx[SS].acc;
        res_v    = sv[SS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg   <= skid_valid_reg || (pipe_en && res_v);
            skid_valid_reg <= 1'b0;
        end else if (pipe_en && res_v) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_tdata_reg <= skid_data_reg;
                m_tuser_reg <= skid_user_reg;
            end else begin
                m_tdata_reg <= res_data;
                m_tuser_reg <= res_user;
            end
        end else if (pipe_en && res_v) begin
            skid_data_reg <= res_data;
            skid_user_reg <= res_user;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    `PGT_ASSERT(a_skid_needs_output, skid_valid_reg |-> m_tvalid_reg)
    `PGT_ASSERT(a_skid_blocks_input, skid_valid_reg |-> !s_tready)
    `PGT_ASSERT(a_accept_enters_chain, (s_tvalid && s_tready) |=> v0_reg)
    `PGT_ASSERT(a_reject_gives_zero, (m_tvalid_reg && !m_tuser_reg) |-> (m_tdata_reg == 64'd0))
    `PGT_ASSERT_ALWAYS(a_reset_clears_output, !$past(aresetn) |-> !m_tvalid_reg)

endmodule
